// File: rtl/core/ncomx_pkg.sv
`default_nettype none
package ncomx_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_WIDTH    = 16;

  localparam int TRIG_DEPTH   = 1 << SINE_TABLE_BITS;
  localparam int TRIG_W       = 16;
  localparam int ERR_W        = 32;
  localparam int ACC_W        = 48;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int CORDIC_STEPS = 16;
  localparam longint CORDIC_START = 64'sd652032874;

  localparam logic signed [ERR_W-1:0] ONE_Q8  = 32'sd256;
  localparam logic signed [ERR_W-1:0] HALF_Q8 = 32'sd128;

  localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN       = 2'd0,
    CFG_I_GAIN       = 2'd1,
    CFG_HZ_PER_BIN   = 2'd2,
    CFG_PHASE_PER_HZ = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    KIND_ERR = 1'b0,
    KIND_SMP = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic                           command;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
    logic signed [ERR_W-1:0]        ifo_bins;
    logic signed [ERR_W-1:0]        coarse_error;
    logic signed [ERR_W-1:0]        residual_error;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_re;
    logic signed [SAMPLE_WIDTH-1:0] out_im;
  } out_word_t;

  typedef struct packed {
    item_kind_e                     kind;
    logic signed [SAMPLE_WIDTH-1:0] re;
    logic signed [SAMPLE_WIDTH-1:0] im;
    logic signed [ERR_W-1:0]        ifo;
    logic signed [ERR_W-1:0]        crs;
    logic signed [ERR_W-1:0]        res;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef enum logic [3:0] {
    B_IDLE, B_EMUL, B_ESEL, B_PMUL, B_PACC, B_SUM, B_MLO, B_MHI, B_STEP,
    B_RMUL, B_ROUT
  } back_state_e;

  typedef logic [2*TRIG_W-1:0] trig_lut_t [TRIG_DEPTH];

  // cos in the upper half, sin in the lower half, by integer CORDIC
  function automatic trig_lut_t build_trig_lut();
    trig_lut_t   lut;
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    logic [31:0] a;
    bit          neg;
    for (int k = 0; k < TRIG_DEPTH; k++) begin
      a   = 32'(k) << (32 - SINE_TABLE_BITS);
      z   = longint'(signed'(a));
      x   = CORDIC_START;
      y   = 0;
      neg = 1'b0;
      if (z > 64'sd1073741824) begin
        z   = z - 64'sd2147483648;
        neg = 1'b1;
      end else if (z < -64'sd1073741824) begin
        z   = z + 64'sd2147483648;
        neg = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_TURNS[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_TURNS[i];
        end
      end
      if (neg) begin
        x = -x;
        y = -y;
      end
      x = (x + 16384) >>> 15;
      y = (y + 16384) >>> 15;
      if (x > 32767) x = 32767;
      if (x < -32767) x = -32767;
      if (y > 32767) y = 32767;
      if (y < -32767) y = -32767;
      lut[k] = {TRIG_W'(x), TRIG_W'(y)};
    end
    return lut;
  endfunction

  localparam trig_lut_t TRIG_LUT = build_trig_lut();

endpackage
`default_nettype wire

// File: rtl/core/ncomx_front.sv
`default_nettype none
module ncomx_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ncomx_pkg::in_word_t in_word_i,
  output ncomx_pkg::q_head_t       head_o,
  input  wire logic                pop_i
);
  import ncomx_pkg::*;

  localparam int QD = 2;

  q_entry_t   mem_q [QD];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic       pop;
  q_entry_t   entry;

  assign in_stall_o = (cnt_q == 2'(QD));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  // classify: keep only what the back end needs for each kind
  always_comb begin
    entry      = '0;
    entry.kind = in_word_i.command ? KIND_SMP : KIND_ERR;
    if (in_word_i.command) begin
      entry.re = in_word_i.sample_re;
      entry.im = in_word_i.sample_im;
    end else begin
      entry.ifo = in_word_i.ifo_bins;
      entry.crs = in_word_i.coarse_error;
      entry.res = in_word_i.residual_error;
    end
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = mem_q[rd_ptr_q];

endmodule
`default_nettype wire

// File: rtl/core/ncomx_back.sv
`default_nettype none
module ncomx_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ncomx_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [ncomx_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire ncomx_pkg::q_head_t                  head_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output ncomx_pkg::out_word_t                     out_word_o
);
  import ncomx_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + TRIG_W;
  localparam int RSUM_W = PROD_W + 1;
  localparam int RSH_W  = RSUM_W - 15;

  back_state_e state_q, state_d;

  logic [15:0] p_gain_q;
  logic [15:0] i_gain_q;
  logic [23:0] hz_per_bin_q;
  logic [31:0] phase_per_hz_q;

  logic signed [ACC_W-1:0] integ_q;
  logic [31:0]             phase_q;
  logic [31:0]             step_q;

  logic signed [ERR_W-1:0] ifo_q, crs_q, res_q;
  logic signed [56:0]      fprod_q;
  logic signed [ACC_W-1:0] err_q;
  logic signed [64:0]      pprod_q, iprod_q;
  logic signed [ACC_W:0]   sum_q;
  logic [55:0]             lo_q;
  logic signed [57:0]      hi_q;

  logic signed [SAMPLE_WIDTH-1:0] re_q, im_q;
  logic signed [TRIG_W-1:0]       cos_q, sin_q;
  logic signed [PROD_W-1:0]       rc_q, is_q, rs_q, ic_q;

  logic      out_valid_q;
  out_word_t out_word_q;

  logic                    out_free;
  logic                    load_out;
  logic signed [49:0]      err_full;
  logic signed [ACC_W-1:0] err_sat;
  logic signed [ACC_W:0]   integ_sum;
  logic signed [ACC_W-1:0] integ_sat;
  logic signed [ACC_W-1:0] prop_sh;
  logic signed [63:0]      step_full;
  logic [2*TRIG_W-1:0]     trig_ent;
  out_word_t               out_word_d;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [49:0] v);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    hi = 50'sd140737488355327;
    lo = -50'sd140737488355328;
    if (v > hi) return ACC_W'(hi);
    if (v < lo) return ACC_W'(lo);
    return ACC_W'(v);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rnd_sat(
    input logic signed [RSUM_W-1:0] v
  );
    logic signed [RSUM_W-1:0] r;
    logic signed [RSH_W-1:0]  s;
    logic signed [RSH_W-1:0]  hi;
    logic signed [RSH_W-1:0]  lo;
    r  = v + RSUM_W'(16384);
    s  = RSH_W'(r >>> 15);
    hi = RSH_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
    lo = -hi - RSH_W'(1);
    if (s > hi) return SAMPLE_WIDTH'(hi);
    if (s < lo) return SAMPLE_WIDTH'(lo);
    return SAMPLE_WIDTH'(s);
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign trig_ent = TRIG_LUT[phase_q[31 -: SINE_TABLE_BITS]];

  // pick the error: offset in bins, then coarse, then residual
  always_comb begin
    if (ifo_q >= ONE_Q8 || ifo_q <= -ONE_Q8) begin
      err_full = -(50'(fprod_q >>> 8));
    end else if (crs_q >= HALF_Q8 || crs_q <= -HALF_Q8) begin
      err_full = -(50'(crs_q));
    end else begin
      err_full = -(50'(res_q));
    end
    err_sat = sat_acc(err_full);
  end

  always_comb begin
    integ_sum = (ACC_W+1)'(integ_q) + (ACC_W+1)'(signed'(iprod_q[63:16]));
    integ_sat = sat_acc(50'(integ_sum));
    prop_sh   = signed'(pprod_q[63:16]);
  end

  assign step_full = (64'(hi_q) <<< 24) + signed'({8'd0, lo_q});

  always_comb begin
    out_word_d.out_re = rnd_sat(RSUM_W'(rc_q) - RSUM_W'(is_q));
    out_word_d.out_im = rnd_sat(RSUM_W'(rs_q) + RSUM_W'(ic_q));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (head_i.valid) begin
          state_d = (head_i.entry.kind == KIND_SMP) ? B_RMUL : B_EMUL;
        end
      end
      B_EMUL: state_d = B_ESEL;
      B_ESEL: state_d = B_PMUL;
      B_PMUL: state_d = B_PACC;
      B_PACC: state_d = B_SUM;
      B_SUM:  state_d = B_MLO;
      B_MLO:  state_d = B_MHI;
      B_MHI:  state_d = B_STEP;
      B_STEP: state_d = B_IDLE;
      B_RMUL: state_d = B_ROUT;
      B_ROUT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      B_IDLE:  pop_o    = head_i.valid;
      B_ROUT:  load_out = out_free;
      default: begin
        pop_o    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_IDLE;
      p_gain_q       <= '0;
      i_gain_q       <= '0;
      hz_per_bin_q   <= '0;
      phase_per_hz_q <= '0;
      integ_q        <= '0;
      phase_q        <= '0;
      step_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_P_GAIN:       p_gain_q       <= cfg_data_i[15:0];
          CFG_I_GAIN:       i_gain_q       <= cfg_data_i[15:0];
          CFG_HZ_PER_BIN:   hz_per_bin_q   <= cfg_data_i[23:0];
          CFG_PHASE_PER_HZ: phase_per_hz_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (pop_o && head_i.entry.kind == KIND_SMP) begin
        phase_q <= phase_q + step_q;
      end
      if (state_q == B_PACC) begin
        integ_q <= integ_sat;
      end
      if (state_q == B_STEP) begin
        step_q <= step_full[63:32];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ifo_q <= head_i.entry.ifo;
      crs_q <= head_i.entry.crs;
      res_q <= head_i.entry.res;
      re_q  <= head_i.entry.re;
      im_q  <= head_i.entry.im;
      cos_q <= signed'(trig_ent[2*TRIG_W-1:TRIG_W]);
      sin_q <= signed'(trig_ent[TRIG_W-1:0]);
    end
    case (state_q)
      B_EMUL: fprod_q <= ifo_q * signed'({1'b0, hz_per_bin_q});
      B_ESEL: err_q   <= err_sat;
      B_PMUL: begin
        pprod_q <= err_q * signed'({1'b0, p_gain_q});
        iprod_q <= err_q * signed'({1'b0, i_gain_q});
      end
      B_SUM:  sum_q <= (ACC_W+1)'(prop_sh) + (ACC_W+1)'(integ_q);
      B_MLO:  lo_q  <= sum_q[23:0] * phase_per_hz_q;
      B_MHI:  hi_q  <= signed'(sum_q[ACC_W:24]) * signed'({1'b0, phase_per_hz_q});
      B_RMUL: begin
        rc_q <= re_q * cos_q;
        is_q <= im_q * sin_q;
        rs_q <= re_q * sin_q;
        ic_q <= im_q * cos_q;
      end
      default: ;
    endcase
    if (load_out) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

// File: rtl/core/nco_mixer_pi_frequency_correction_top.sv
// Channel   Direction  Handshake              Word
// in        input      in_valid_i/in_stall_o  in_word_i   (command, sample, errors)
// out       output     out_valid_o/out_stall_i out_word_o (rotated sample)
// cfg       input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// In the back-end sequencer a sample word goes through a pop with sine table
// read, a multiply state and a round/saturate state into the output register.
// An error word uses the same sequencer: the PI filter and the 49x32 phase step
// product share it, split into partial products of at most 25x33 bits.
// A 2-deep queue sits between the front and the back, so input is taken while
// the back is busy or the output waits. Reset clears control and loop state.
`default_nettype none
module nco_mixer_pi_frequency_correction_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire ncomx_pkg::in_word_t              in_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output ncomx_pkg::out_word_t                  out_word_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ncomx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [ncomx_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ncomx_pkg::*;

  q_head_t head;
  logic    pop;

  // accept and classify words, hold them in the queue
  ncomx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // run the loop filter or rotate the sample, in queue order
  ncomx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/ncomx_checker.sv
`default_nettype none
module ncomx_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire ncomx_pkg::out_word_t out_word_o
);
  import ncomx_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word dropped or changed");

  // no result can appear right after reset: reset clears the output valid flag
  a_rst_out: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

  // the queue comes out of reset empty
  a_rst_stall: assert property (@(posedge clk_i) !rst_ni |=> !in_stall_o)
    else $error("input stalled right after reset");

  // a valid output word carries known bits
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_word_o))
    else $error("output word has unknown bits");

endmodule

bind nco_mixer_pi_frequency_correction_top ncomx_checker u_ncomx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
`default_nettype wire
